// ----- rtl/skes_pkg.sv -----
// Shared constants, types and gesture tables of the servo keyframe sequencer.
`default_nettype none

package skes_pkg;

    localparam int FRAC_BITS = 8;
    localparam int TIME_BITS = 32;
    localparam int DEG_W     = 8;
    localparam int POS_W     = DEG_W + FRAC_BITS;
    localparam int EASE_W    = 9;
    localparam int HOLD_W    = 11;
    localparam int STEP_W    = 3;
    localparam int GEST_W    = 4;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam int NUM_GESTURES = 10;
    localparam int STEP_SLOTS   = 8;

    // Unity easing factor in Q1.8.
    localparam logic [EASE_W-1:0] EASE_ONE = EASE_W'(256);

    // Item kinds.
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_SET     = 2'd1;
    localparam logic [1:0] MODE_GESTURE = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_MIN    = 2'd0;
    localparam logic [1:0] REG_MAX    = 2'd1;
    localparam logic [1:0] REG_CENTER = 2'd2;
    localparam logic [1:0] REG_EASE   = 2'd3;

    // Register values after reset.
    localparam logic [DEG_W-1:0]  MIN_RESET    = DEG_W'(0);
    localparam logic [DEG_W-1:0]  MAX_RESET    = DEG_W'(180);
    localparam logic [DEG_W-1:0]  CENTER_RESET = DEG_W'(90);
    localparam logic [EASE_W-1:0] EASE_RESET   = EASE_W'(38);

    typedef struct packed {
        logic [DEG_W-1:0]  min_angle;
        logic [DEG_W-1:0]  max_angle;
        logic [DEG_W-1:0]  center_angle;
        logic [EASE_W-1:0] easing_factor;
    } cfg_t;

    // Number of keyframes in each gesture.
    localparam logic [STEP_W-1:0] G_LEN [NUM_GESTURES] =
        '{3'd4, 3'd5, 3'd2, 3'd2, 3'd3, 3'd7, 3'd5, 3'd4, 3'd4, 3'd4};

    // Keyframe angles in degrees; unused slots are zero.
    localparam logic [DEG_W-1:0] G_ANG [NUM_GESTURES][STEP_SLOTS] = '{
        '{8'd72,  8'd104, 8'd75,  8'd90,  8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd112, 8'd68,  8'd108, 8'd72,  8'd90,  8'd0,  8'd0,  8'd0},
        '{8'd68,  8'd90,  8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd112, 8'd90,  8'd0,   8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd116, 8'd110, 8'd90,  8'd0,   8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd115, 8'd65,  8'd112, 8'd68,  8'd105, 8'd75, 8'd90, 8'd0},
        '{8'd84,  8'd96,  8'd86,  8'd94,  8'd90,  8'd0,  8'd0,  8'd0},
        '{8'd74,  8'd72,  8'd94,  8'd90,  8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd114, 8'd80,  8'd98,  8'd90,  8'd0,   8'd0,  8'd0,  8'd0},
        '{8'd76,  8'd76,  8'd104, 8'd90,  8'd0,   8'd0,  8'd0,  8'd0}
    };

    // Keyframe hold times in ms; unused slots are zero.
    localparam logic [HOLD_W-1:0] G_HOLD [NUM_GESTURES][STEP_SLOTS] = '{
        '{11'd220,  11'd220,  11'd200, 11'd200, 11'd0,   11'd0,   11'd0,   11'd0},
        '{11'd180,  11'd180,  11'd160, 11'd160, 11'd200, 11'd0,   11'd0,   11'd0},
        '{11'd1100, 11'd300,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0},
        '{11'd1100, 11'd300,  11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0},
        '{11'd300,  11'd1300, 11'd350, 11'd0,   11'd0,   11'd0,   11'd0,   11'd0},
        '{11'd130,  11'd130,  11'd120, 11'd120, 11'd110, 11'd110, 11'd200, 11'd0},
        '{11'd350,  11'd350,  11'd300, 11'd300, 11'd250, 11'd0,   11'd0,   11'd0},
        '{11'd600,  11'd1400, 11'd400, 11'd300, 11'd0,   11'd0,   11'd0,   11'd0},
        '{11'd120,  11'd140,  11'd160, 11'd200, 11'd0,   11'd0,   11'd0,   11'd0},
        '{11'd300,  11'd800,  11'd900, 11'd300, 11'd0,   11'd0,   11'd0,   11'd0}
    };

endpackage

`default_nettype wire

// ----- rtl/skes_if.sv -----
// Valid/ready channel interfaces for command and result transactions.
`default_nettype none

interface skes_cmd_if;
    import skes_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [31:0]       now_ms;
    logic [DEG_W-1:0]  target_angle;
    logic [GEST_W-1:0] gesture_code;

    modport source (output valid, mode, now_ms, target_angle, gesture_code, input ready);
    modport sink   (input valid, mode, now_ms, target_angle, gesture_code, output ready);
endinterface

interface skes_res_if;
    import skes_pkg::*;

    logic             valid;
    logic             ready;
    logic [DEG_W-1:0] servo_angle;
    logic             angle_written;
    logic             gesture_busy;

    modport source (output valid, servo_angle, angle_written, gesture_busy, input ready);
    modport sink   (input valid, servo_angle, angle_written, gesture_busy, output ready);
endinterface

`default_nettype wire

// ----- rtl/skes_regs.sv -----
// APB configuration register file of the servo keyframe sequencer.
`default_nettype none

module skes_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [skes_pkg::ADDR_W-1:0] paddr,
    input  wire logic [skes_pkg::DATA_W-1:0] pwdata,
    output logic      [skes_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output skes_pkg::cfg_t             cfg
);
    import skes_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_angle     <= MIN_RESET;
            cfg_reg.max_angle     <= MAX_RESET;
            cfg_reg.center_angle  <= CENTER_RESET;
            cfg_reg.easing_factor <= EASE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN:    cfg_reg.min_angle     <= pwdata[DEG_W-1:0];
                REG_MAX:    cfg_reg.max_angle     <= pwdata[DEG_W-1:0];
                REG_CENTER: cfg_reg.center_angle  <= pwdata[DEG_W-1:0];
                REG_EASE:   cfg_reg.easing_factor <= pwdata[EASE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN:    prdata = DATA_W'(cfg_reg.min_angle);
            REG_MAX:    prdata = DATA_W'(cfg_reg.max_angle);
            REG_CENTER: prdata = DATA_W'(cfg_reg.center_angle);
            REG_EASE:   prdata = DATA_W'(cfg_reg.easing_factor);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/servo_keyframe_sequencer_easing.sv -----
// Top level of the servo keyframe sequencer with easing.
//
// Commands arrive as transactions on the cmd channel (valid/ready). A tick
// carries the current ms time: if a running gesture is due it loads the next
// keyframe or ends the gesture and returns to the center angle, then the
// Q8.8 position moves toward the target by the easing factor. A set-target
// command clamps and stores a new target unless a gesture runs, and a gesture
// command (re)starts one of ten built-in gestures from its first keyframe.
// Every command yields exactly one result transaction on the res channel with
// the clamped servo angle, a flag marking ticks and the gesture busy flag.
//
// A command is captured in an input register, evaluated combinationally by
// the easing and sequencing logic, including the 16x9 easing multiply, and
// lands in the result register. One command per cycle is sustained while
// the receiver does not stall. When the receiver stalls, the result register
// holds, the input register keeps its command, and cmd.ready drops only once
// both are occupied. Reset empties both registers, loads the configuration
// defaults and parks the position at 90 degrees with no gesture running.
// Configuration is to be written by the user through the APB port only while
// no command is in flight; the block itself does not enforce this.
`default_nettype none

module servo_keyframe_sequencer_easing (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    skes_cmd_if.sink                         cmd,
    skes_res_if.source                       res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [skes_pkg::ADDR_W-1:0] paddr,
    input  wire logic [skes_pkg::DATA_W-1:0] pwdata,
    output logic      [skes_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import skes_pkg::*;

    cfg_t cfg;

    skes_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register: holds one command until the result register can take it.
    logic              s1_valid_reg;
    logic [1:0]        s1_mode_reg;
    logic [TIME_BITS-1:0] s1_now_reg;
    logic [DEG_W-1:0]  s1_tgt_reg;
    logic [GEST_W-1:0] s1_code_reg;

    // Sequencer state.
    logic [POS_W-1:0]     pos_reg,  pos_next;
    logic [DEG_W-1:0]     tgt_reg,  tgt_next;
    logic                 run_reg,  run_next;
    logic [GEST_W-1:0]    gest_reg, gest_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [TIME_BITS-1:0] due_reg,  due_next;

    // Result register.
    logic             res_valid_reg;
    logic [DEG_W-1:0] res_angle_reg, res_angle_next;
    logic             res_wr_reg,    res_wr_next;
    logic             res_busy_reg,  res_busy_next;

    logic s1_advance;
    logic cmd_fire;

    // The input register moves on whenever the result register is free or
    // is being emptied in the same cycle.
    assign s1_advance = !res_valid_reg || res.ready;
    assign cmd.ready  = !s1_valid_reg || s1_advance;
    assign cmd_fire   = cmd.valid && cmd.ready;

    assign res.valid         = res_valid_reg;
    assign res.servo_angle   = res_angle_reg;
    assign res.angle_written = res_wr_reg;
    assign res.gesture_busy  = res_busy_reg;

    function automatic logic [DEG_W-1:0] clamp_deg(input logic [DEG_W-1:0] x,
                                                   input cfg_t c);
        logic [DEG_W-1:0] r;
        if (x < c.min_angle)
            r = c.min_angle;
        else if (x > c.max_angle)
            r = c.max_angle;
        else
            r = x;
        return r;
    endfunction

    // Evaluation of the command in the input register.
    logic [POS_W-1:0]        goal;
    logic                    move_up;
    logic [POS_W-1:0]        span;
    logic [EASE_W-1:0]       ease_f;
    logic [POS_W+EASE_W-1:0] prod;
    logic [POS_W+EASE_W-1:0] prod_rnd;
    logic [POS_W-1:0]        delta;
    logic                    due;
    logic [STEP_W-1:0]       cur_len;

    always_comb
    begin
        pos_next  = pos_reg;
        tgt_next  = tgt_reg;
        run_next  = run_reg;
        gest_next = gest_reg;
        step_next = step_reg;
        due_next  = due_reg;

        cur_len = G_LEN[gest_reg];
        due     = run_reg && (s1_now_reg >= due_reg);

        case (s1_mode_reg)
            MODE_TICK:
            begin
                if (due)
                begin
                    if (step_reg < cur_len)
                    begin
                        tgt_next  = G_ANG[gest_reg][step_reg];
                        due_next  = s1_now_reg + TIME_BITS'(G_HOLD[gest_reg][step_reg]);
                        step_next = step_reg + STEP_W'(1);
                    end
                    else
                    begin
                        run_next = 1'b0;
                        tgt_next = cfg.center_angle;
                    end
                end
            end
            MODE_SET:
            begin
                if (!run_reg)
                    tgt_next = clamp_deg(s1_tgt_reg, cfg);
            end
            MODE_GESTURE:
            begin
                if (s1_code_reg < GEST_W'(NUM_GESTURES))
                begin
                    gest_next = s1_code_reg;
                    run_next  = 1'b1;
                    step_next = '0;
                    due_next  = s1_now_reg;
                end
            end
            default: ;
        endcase

        // Easing: move by |distance| * factor / 256, rounded up in magnitude.
        goal     = {tgt_next, {FRAC_BITS{1'b0}}};
        move_up  = goal >= pos_reg;
        span     = move_up ? goal - pos_reg : pos_reg - goal;
        ease_f   = (cfg.easing_factor > EASE_ONE) ? EASE_ONE : cfg.easing_factor;
        prod     = (POS_W+EASE_W)'(span) * (POS_W+EASE_W)'(ease_f);
        prod_rnd = prod + (POS_W+EASE_W)'(255);
        delta    = prod_rnd[POS_W+7:8];
        if (s1_mode_reg == MODE_TICK)
            pos_next = move_up ? pos_reg + delta : pos_reg - delta;

        res_angle_next = clamp_deg(pos_next[POS_W-1:FRAC_BITS], cfg);
        res_wr_next    = (s1_mode_reg == MODE_TICK);
        res_busy_next  = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= {CENTER_RESET, {FRAC_BITS{1'b0}}};
            tgt_reg       <= CENTER_RESET;
            run_reg       <= 1'b0;
            gest_reg      <= '0;
            step_reg      <= '0;
            due_reg       <= '0;
        end
        else
        begin
            if (cmd.ready)
                s1_valid_reg <= cmd.valid;
            if (s1_advance)
                res_valid_reg <= s1_valid_reg;
            if (s1_valid_reg && s1_advance)
            begin
                pos_reg  <= pos_next;
                tgt_reg  <= tgt_next;
                run_reg  <= run_next;
                gest_reg <= gest_next;
                step_reg <= step_next;
                due_reg  <= due_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_mode_reg <= cmd.mode;
            s1_now_reg  <= cmd.now_ms[TIME_BITS-1:0];
            s1_tgt_reg  <= cmd.target_angle;
            s1_code_reg <= cmd.gesture_code;
        end
        if (s1_valid_reg && s1_advance)
        begin
            res_angle_reg <= res_angle_next;
            res_wr_reg    <= res_wr_next;
            res_busy_reg  <= res_busy_next;
        end
    end

    // A running gesture always refers to an existing table row.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (gest_reg < GEST_W'(NUM_GESTURES)))
        else $error("running gesture index out of range");

    // The step index never passes the length of the running gesture.
    assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (step_reg <= G_LEN[gest_reg]))
        else $error("gesture step index beyond gesture length");

    // An accepted command always occupies the input register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> s1_valid_reg)
        else $error("accepted command lost");

    // A stalled result with a waiting command keeps that command held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && res_valid_reg && !res.ready) |=> s1_valid_reg)
        else $error("pending command dropped during stall");

endmodule

`default_nettype wire
